// File: hdl/tsls_pkg.sv
// Shared types and constants for the TCP timestamp low-bit scrubber.
// Used by tsls_front, tsls_queue, tsls_back and the top level.
`default_nettype none

package tsls_pkg;

    localparam int VLAN_DEPTH    = 2;
    localparam int OPTION_WINDOW = 12;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_VLAN   = 16'h8100;
    localparam logic [15:0] ETH_QINQ   = 16'h88A8;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [31:0] STAMP_HEAD = 32'h0101080A;
    localparam logic [7:0]  IP_START   = 8'd14;
    localparam logic [3:0]  MIN_WORDS  = 4'd5;
    localparam logic [8:0]  FIXED_HDR  = 9'd20;
    localparam logic [7:0]  SUM_OFS    = 8'd16;
    localparam logic [7:0]  TS_LSB_OFS = 8'd27;
    localparam logic [7:0]  POS_MAX    = 8'd255;

    typedef enum logic [2:0] {
        V_NOT_IPV4  = 3'd0,
        V_NOT_TCP   = 3'd1,
        V_NO_STAMP  = 3'd2,
        V_LSB_CLEAR = 3'd3,
        V_REWRITTEN = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } byte_req_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        rewrite;
        logic [7:0]  ts_byte_offset;
        logic [7:0]  ts_byte_value;
        logic [7:0]  sum_offset;
        logic [15:0] new_sum;
    } result_t;

    // Header summary of one finished frame, handed from front to back.
    typedef struct packed {
        logic [8:0]  frame_len;
        logic [7:0]  ip_start;
        logic [3:0]  ip_words;
        logic [3:0]  tcp_words;
        logic        is_ipv4;
        logic        is_tcp;
        logic        head_ok;
        logic [15:0] sum_held;
        logic [15:0] stamp_low;
    } frame_rec_t;

endpackage

`default_nettype wire

// File: hdl/tsls_queue.sv
// Short FIFO of frame summaries between the parser and the verdict stage.
// Depends on tsls_pkg for the record type.
`default_nettype none

module tsls_queue #(
    parameter int DEPTH = tsls_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tsls_pkg::frame_rec_t push_rec,
    output logic                     full,
    input  wire logic                pop,
    output logic                     head_valid,
    output tsls_pkg::frame_rec_t     head_rec
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsls_pkg::frame_rec_t entry_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// File: hdl/tsls_front.sv
// Byte parser: tracks header fields of the frame in flight and pushes a
// summary into the queue on the final byte. Depends on tsls_pkg.
`default_nettype none

module tsls_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire tsls_pkg::byte_req_t byte_data,
    output logic                     push,
    output tsls_pkg::frame_rec_t     push_rec,
    input  wire logic                queue_full
);

    logic [7:0]  pos_reg, pos_next;
    logic [1:0]  tag_reg, tag_next;
    logic [15:0] ek_reg, ek_next;
    logic [7:0]  ips_reg, ips_next;
    logic [3:0]  ipw_reg, ipw_next;
    logic [7:0]  proto_reg, proto_next;
    logic [3:0]  tcpw_reg, tcpw_next;
    logic [15:0] sum_reg, sum_next;
    logic [31:0] head_reg, head_next;
    logic [15:0] stamp_reg, stamp_next;
    logic [7:0]  tcp_start;
    logic [7:0]  b;
    logic        accept;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !byte_stall;
    assign b          = byte_data.frame_byte;
    assign tcp_start  = ips_reg + {2'b00, ipw_reg, 2'b00};

    always_comb
    begin
        ek_next    = ek_reg;
        tag_next   = tag_reg;
        ips_next   = ips_reg;
        ipw_next   = ipw_reg;
        proto_next = proto_reg;
        tcpw_next  = tcpw_reg;
        sum_next   = sum_reg;
        head_next  = head_reg;
        stamp_next = stamp_reg;
        if (pos_reg != tsls_pkg::POS_MAX)
        begin
            if (pos_reg == ips_reg - 8'd2)
            begin
                ek_next = {ek_reg[7:0], b};
            end
            else if (pos_reg == ips_reg - 8'd1)
            begin
                ek_next = {ek_reg[7:0], b};
                // A VLAN tag pushes the IPv4 header back by four bytes.
                if ((ek_next == tsls_pkg::ETH_VLAN || ek_next == tsls_pkg::ETH_QINQ)
                    && tag_reg < 2'(tsls_pkg::VLAN_DEPTH))
                begin
                    tag_next = tag_reg + 2'd1;
                    ips_next = ips_reg + 8'd4;
                end
            end
            else if (pos_reg == ips_reg)
            begin
                ipw_next = b[3:0];
            end
            else if (pos_reg == ips_reg + 8'd9)
            begin
                proto_next = b;
            end
            if (pos_reg > ips_reg + 8'd9)
            begin
                if (pos_reg == tcp_start + 8'd12)
                begin
                    tcpw_next = b[7:4];
                end
                else if (pos_reg == tcp_start + 8'd16 || pos_reg == tcp_start + 8'd17)
                begin
                    sum_next = {sum_reg[7:0], b};
                end
                else if (pos_reg >= tcp_start + 8'd20 && pos_reg < tcp_start + 8'd24)
                begin
                    head_next = {head_reg[23:0], b};
                end
                else if (pos_reg >= tcp_start + 8'd24 && pos_reg < tcp_start + 8'd28)
                begin
                    stamp_next = {stamp_reg[7:0], b};
                end
            end
        end
        pos_next = (pos_reg == tsls_pkg::POS_MAX) ? pos_reg : pos_reg + 8'd1;
    end

    always_comb
    begin
        push                = accept && byte_data.frame_end;
        push_rec.frame_len  = {1'b0, pos_reg} + 9'd1;
        push_rec.ip_start   = ips_next;
        push_rec.ip_words   = ipw_next;
        push_rec.tcp_words  = tcpw_next;
        push_rec.is_ipv4    = (ek_next == tsls_pkg::ETH_IPV4);
        push_rec.is_tcp     = (proto_next == tsls_pkg::PROTO_TCP);
        push_rec.head_ok    = (head_next == tsls_pkg::STAMP_HEAD);
        push_rec.sum_held   = sum_next;
        push_rec.stamp_low  = stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            tag_reg   <= '0;
            ek_reg    <= '0;
            ips_reg   <= tsls_pkg::IP_START;
            ipw_reg   <= '0;
            proto_reg <= '0;
            tcpw_reg  <= '0;
            sum_reg   <= '0;
            head_reg  <= '0;
            stamp_reg <= '0;
        end
        else if (accept)
        begin
            if (byte_data.frame_end)
            begin
                // Start over for the next frame.
                pos_reg   <= '0;
                tag_reg   <= '0;
                ek_reg    <= '0;
                ips_reg   <= tsls_pkg::IP_START;
                ipw_reg   <= '0;
                proto_reg <= '0;
                tcpw_reg  <= '0;
                sum_reg   <= '0;
                head_reg  <= '0;
                stamp_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                tag_reg   <= tag_next;
                ek_reg    <= ek_next;
                ips_reg   <= ips_next;
                ipw_reg   <= ipw_next;
                proto_reg <= proto_next;
                tcpw_reg  <= tcpw_next;
                sum_reg   <= sum_next;
                head_reg  <= head_next;
                stamp_reg <= stamp_next;
            end
        end
    end

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_data.frame_end |=> pos_reg == '0 && ips_reg == tsls_pkg::IP_START)
        else $error("parser did not restart after frame end");

endmodule

`default_nettype wire

// File: hdl/tsls_back.sv
// Verdict stage: judges one frame summary, computes the patched checksum
// and holds the result in an output register. Depends on tsls_pkg.
`default_nettype none

module tsls_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire tsls_pkg::frame_rec_t head_rec,
    output logic                      pop,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output tsls_pkg::result_t         res_data
);

    logic              res_valid_reg, res_valid_next;
    tsls_pkg::result_t res_reg, res_next;
    logic [8:0]        len, ips9, tcp9;
    logic [15:0]       oldw, neww;
    logic [17:0]       sum1;
    logic [16:0]       sum2;
    logic [15:0]       sum3;

    assign pop       = head_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    assign len  = head_rec.frame_len;
    assign ips9 = {1'b0, head_rec.ip_start};
    assign tcp9 = ips9 + {3'b000, head_rec.ip_words, 2'b00};

    // Incremental update over the one changed word: ~(~HC + ~m + m').
    assign oldw = head_rec.stamp_low;
    assign neww = {oldw[15:1], 1'b0};
    assign sum1 = {2'b00, ~head_rec.sum_held} + {2'b00, ~oldw} + {2'b00, neww};
    assign sum2 = {1'b0, sum1[15:0]} + {15'd0, sum1[17:16]};
    assign sum3 = sum2[15:0] + {15'd0, sum2[16]};

    always_comb
    begin
        res_next = '0;
        if (len < ips9 || !head_rec.is_ipv4)
        begin
            res_next.verdict = tsls_pkg::V_NOT_IPV4;
        end
        else if (len < ips9 + tsls_pkg::FIXED_HDR || head_rec.ip_words < tsls_pkg::MIN_WORDS
                 || len < tcp9)
        begin
            res_next.verdict = tsls_pkg::V_NOT_IPV4;
        end
        else if (!head_rec.is_tcp)
        begin
            res_next.verdict = tsls_pkg::V_NOT_TCP;
        end
        else if (len < tcp9 + tsls_pkg::FIXED_HDR || head_rec.tcp_words < tsls_pkg::MIN_WORDS
                 || len < tcp9 + {3'b000, head_rec.tcp_words, 2'b00})
        begin
            res_next.verdict = tsls_pkg::V_NOT_IPV4;
        end
        else if (len < tcp9 + tsls_pkg::FIXED_HDR + 9'(tsls_pkg::OPTION_WINDOW)
                 || !head_rec.head_ok)
        begin
            res_next.verdict = tsls_pkg::V_NO_STAMP;
        end
        else if (!oldw[0])
        begin
            res_next.verdict = tsls_pkg::V_LSB_CLEAR;
        end
        else
        begin
            res_next.verdict        = tsls_pkg::V_REWRITTEN;
            res_next.rewrite        = 1'b1;
            res_next.ts_byte_offset = tcp9[7:0] + tsls_pkg::TS_LSB_OFS;
            res_next.ts_byte_value  = neww[7:0];
            res_next.sum_offset     = tcp9[7:0] + tsls_pkg::SUM_OFS;
            res_next.new_sum        = ~sum3;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.verdict != tsls_pkg::V_REWRITTEN
        |-> !res_reg.rewrite && res_reg.new_sum == '0 && res_reg.sum_offset == '0)
        else $error("edit fields set without a rewrite verdict");

endmodule

`default_nettype wire

// File: hdl/tcp_tsval_lsb_scrubber_unit.sv
// Top level of the TCP timestamp low-bit scrubber.
// Instantiates tsls_front, tsls_queue and tsls_back; depends on tsls_pkg.
`default_nettype none

// Takes an Ethernet frame one byte per cycle and, on the final byte, queues
// a header summary, and the verdict stage then loads its output register
// (edit offsets, patched byte and new TCP checksum when the timestamp lsb
// must be cleared). Throughput is one byte per cycle with no gap between
// frames; a frame of one byte is fine. Input stalls only when the summary
// queue (QUEUE_DEPTH entries) is full because the result side is stalled.
module tcp_tsval_lsb_scrubber_unit #(
    parameter int QUEUE_DEPTH = tsls_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire tsls_pkg::byte_req_t byte_data,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output tsls_pkg::result_t        res_data
);

    logic                 push, queue_full, pop, head_valid;
    tsls_pkg::frame_rec_t push_rec, head_rec;

    tsls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .push       (push),
        .push_rec   (push_rec),
        .queue_full (queue_full)
    );

    tsls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    tsls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

`default_nettype wire
